/* hw/rtl/tdnc_pkg.sv */
// shared constants and types of the torus disc neighbour count unit
package tdnc_pkg;

	localparam int MAX_SIZE_DEF   = 512;
	localparam int MAX_RADIUS_DEF = 31;

	localparam int COORD_W     = 9;
	localparam int GRID_W      = 10;
	localparam int RAD_W       = 5;
	localparam int COUNT_W     = 12;
	localparam int COUNT_MAX   = 4095;
	localparam int TDATA_IN_W  = 24;
	localparam int TDATA_OUT_W = 16;

	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;
	localparam int REG_IDX_W = 1;

	localparam logic [GRID_W-1:0] GRID_RESET   = GRID_W'(512);
	localparam logic [RAD_W-1:0]  RADIUS_RESET = RAD_W'(5);

	localparam logic [REG_IDX_W-1:0] REG_GRID_SIZE = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_RADIUS    = REG_IDX_W'(1);

	typedef enum logic {
		REQ_WRITE = 1'b0,
		REQ_QUERY = 1'b1
	} req_type_t;

endpackage

/* hw/rtl/torus_disc_neighbour_count_unit.sv */
// torus disc neighbour count unit: mark grid memory, write and circular count engine
//
// The grid is one memory of MAX_SIZE rows, one row of MAX_SIZE marks per word, read through
// a registered output. After reset the unit clears the memory one row a cycle, so s_tready
// stays low until every row is cleared. Every request first folds row and col into the grid
// in use with a bit-serial remainder unit. A write then reads the row and writes it back with
// the one mark changed. A query walks the column offsets outward from the center column, one
// offset each way per cycle, then reads one row per cycle for 2*radius+1 rows; each row goes
// through a lane select and a registered population count. A query can wait in its done state
// for m_tready while an earlier count is still held. One request is worked on at a time; a
// count waiting on m_tready does not hold back the next request until that next query
// finishes.
module torus_disc_neighbour_count_unit
	import tdnc_pkg::*;
#(
	parameter int MAX_SIZE   = MAX_SIZE_DEF,
	parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [TDATA_IN_W-1:0]  s_tdata,   // row[8:0], col[17:9], mark[18], zero fill
	input  logic                   s_tuser,   // req_type
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [TDATA_OUT_W-1:0] m_tdata,   // count[11:0], zero fill
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [PADDR_W-1:0]     paddr,
	input  logic [PDATA_W-1:0]     pwdata,
	output logic [PDATA_W-1:0]     prdata,
	output logic                   pready
);

	localparam int AW      = $clog2(MAX_SIZE);
	localparam int NW      = $clog2(MAX_SIZE + 1);
	localparam int EW      = (NW > GRID_W) ? NW : GRID_W;
	localparam int RW      = $clog2(MAX_RADIUS + 1);
	localparam int RXW     = (RW > RAD_W) ? RW : RAD_W;
	localparam int LANES   = 2 * MAX_RADIUS + 1;
	localparam int SQ1W    = $clog2(MAX_RADIUS * MAX_RADIUS + 1);
	localparam int SQW     = SQ1W + 1;
	localparam int PCW     = $clog2(LANES + 1);
	localparam int ACC_MAX = LANES * LANES;
	localparam int ACCW    = $clog2(ACC_MAX + 1);
	localparam int XW      = (ACCW > COUNT_W) ? ACCW : COUNT_W;
	localparam int MCW     = $clog2(COORD_W);

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_MOD,
		ST_WALK,
		ST_ROWS,
		ST_DRAIN,
		ST_DONE,
		ST_WRD,
		ST_WWB
	} state_t;

	state_t state_q;

	// configuration
	logic [GRID_W-1:0]    grid_size_q;
	logic [RAD_W-1:0]     radius_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 cfg_wr;

	// control
	logic [AW-1:0]  clr_q;
	logic [MCW-1:0] mcnt_q;
	logic [RW-1:0]  step_q;
	logic           v_s1;
	logic           v_s2;
	logic           m_tvalid_q;
	logic           in_acc;

	// datapath
	logic [COORD_W-1:0]    row_q;
	logic [COORD_W-1:0]    col_q;
	logic                  mark_q;
	req_type_t             type_q;
	logic [AW-1:0]         rem_r_q;
	logic [AW-1:0]         rem_c_q;
	logic [AW-1:0]         up_q;
	logic [AW-1:0]         down_q;
	logic [AW-1:0]         rr_q;
	logic [AW-1:0]         lane_col_q [LANES];
	logic signed [RW:0]    dr_q;
	logic [SQ1W-1:0]       r2_q;
	logic [SQ1W-1:0]       dr2_s1;
	logic [LANES-1:0]      hits_s2;
	logic [ACCW-1:0]       acc_q;
	logic [COUNT_W-1:0]    count_q;

	// derived values
	logic [NW-1:0]      eff_n;
	logic [AW-1:0]      n_m1;
	logic [RW-1:0]      r_eff;
	logic [AW:0]        rem_r_sh;
	logic [AW:0]        rem_c_sh;
	logic [AW-1:0]      rem_r_n;
	logic [AW-1:0]      rem_c_n;
	logic [AW-1:0]      up_n;
	logic [AW-1:0]      down_n;
	logic [AW-1:0]      rr_inc;
	logic [AW-1:0]      rr_dec;
	logic [RW-1:0]      abs_dr;
	logic [LANES-1:0]   hits;
	logic [PCW-1:0]     pop;
	logic [COUNT_W-1:0] count_sat;

	// grid memory
	logic [MAX_SIZE-1:0] mem_q [MAX_SIZE];
	logic [MAX_SIZE-1:0] mem_rdata_q;
	logic [MAX_SIZE-1:0] mem_wdata;
	logic [AW-1:0]       mem_waddr;
	logic [AW-1:0]       mem_raddr;
	logic                mem_we;
	logic                mem_re;

	// configuration port
	assign pready  = 1'b1;
	assign reg_idx = paddr[2 +: REG_IDX_W];
	assign cfg_wr  = psel & penable & pwrite;

	always_comb begin
		unique case (reg_idx)
			REG_GRID_SIZE: prdata = PDATA_W'(grid_size_q);
			REG_RADIUS:    prdata = PDATA_W'(radius_q);
			default:       prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_size_q <= GRID_RESET;
			radius_q    <= RADIUS_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_GRID_SIZE: grid_size_q <= pwdata[GRID_W-1:0];
				REG_RADIUS:    radius_q    <= pwdata[RAD_W-1:0];
				default: ;
			endcase
		end
	end

	// effective size and radius
	always_comb begin
		if (grid_size_q == '0) begin
			eff_n = NW'(1);
		end else if (EW'(grid_size_q) > EW'(MAX_SIZE)) begin
			eff_n = NW'(MAX_SIZE);
		end else begin
			eff_n = NW'(grid_size_q);
		end
		n_m1 = AW'(eff_n - NW'(1));
		if (RXW'(radius_q) > RXW'(MAX_RADIUS)) begin
			r_eff = RW'(MAX_RADIUS);
		end else begin
			r_eff = RW'(radius_q);
		end
	end

	// one restoring remainder step per cycle for row and col
	always_comb begin
		rem_r_sh = {rem_r_q, row_q[mcnt_q]};
		rem_c_sh = {rem_c_q, col_q[mcnt_q]};
		rem_r_n  = (rem_r_sh >= (AW+1)'(eff_n)) ? AW'(rem_r_sh - (AW+1)'(eff_n)) : AW'(rem_r_sh);
		rem_c_n  = (rem_c_sh >= (AW+1)'(eff_n)) ? AW'(rem_c_sh - (AW+1)'(eff_n)) : AW'(rem_c_sh);
	end

	// wrapped neighbors of the walkers
	assign up_n   = (up_q == n_m1) ? '0 : up_q + AW'(1);
	assign down_n = (down_q == '0) ? n_m1 : down_q - AW'(1);
	assign rr_inc = (rr_q == n_m1) ? '0 : rr_q + AW'(1);
	assign rr_dec = (rr_q == '0) ? n_m1 : rr_q - AW'(1);

	assign abs_dr = dr_q[RW] ? RW'(-dr_q) : RW'(dr_q);

	// lane select and circle test on the row just read
	always_comb begin
		int off;
		off = 0;
		for (int k = 0; k < LANES; k++) begin
			off     = k - MAX_RADIUS;
			hits[k] = mem_rdata_q[lane_col_q[k]] &&
				(SQW'(off * off) + SQW'(dr2_s1) <= SQW'(r2_q));
		end
	end

	always_comb begin
		pop = '0;
		for (int k = 0; k < LANES; k++) begin
			pop = pop + PCW'(hits_s2[k]);
		end
	end

	assign count_sat = (XW'(acc_q) > XW'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX) : COUNT_W'(acc_q);

	// memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = rem_r_q;
		mem_raddr = rr_q;
		mem_wdata = mem_rdata_q;
		unique case (state_q)
			ST_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			ST_ROWS: begin
				mem_re = 1'b1;
			end
			ST_WRD: begin
				mem_re    = 1'b1;
				mem_raddr = rem_r_q;
			end
			ST_WWB: begin
				mem_we             = 1'b1;
				mem_wdata[rem_c_q] = mark_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			mem_rdata_q <= mem_q[mem_raddr];
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid & s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(TDATA_OUT_W - COUNT_W){1'b0}}, count_q};

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLR;
			clr_q      <= '0;
			mcnt_q     <= '0;
			step_q     <= '0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_ROWS);
			v_s2 <= v_s1;
			if (state_q == ST_DONE && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(MAX_SIZE - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						mcnt_q  <= MCW'(COORD_W - 1);
						state_q <= ST_MOD;
					end
				end
				ST_MOD: begin
					mcnt_q <= mcnt_q - MCW'(1);
					if (mcnt_q == '0) begin
						step_q  <= RW'(1);
						state_q <= (type_q == REQ_QUERY) ? ST_WALK : ST_WRD;
					end
				end
				ST_WALK: begin
					step_q <= step_q + RW'(1);
					if (step_q == RW'(MAX_RADIUS)) begin
						state_q <= ST_ROWS;
					end
				end
				ST_ROWS: begin
					if (dr_q == $signed({1'b0, r_eff})) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!v_s1 && !v_s2) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				ST_WRD: begin
					state_q <= ST_WWB;
				end
				ST_WWB: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			row_q   <= s_tdata[COORD_W-1:0];
			col_q   <= s_tdata[2*COORD_W-1:COORD_W];
			mark_q  <= s_tdata[2*COORD_W];
			type_q  <= req_type_t'(s_tuser);
			rem_r_q <= '0;
			rem_c_q <= '0;
			acc_q   <= '0;
			r2_q    <= SQ1W'(r_eff) * SQ1W'(r_eff);
		end
		if (state_q == ST_MOD) begin
			rem_r_q <= rem_r_n;
			rem_c_q <= rem_c_n;
			if (mcnt_q == '0) begin
				up_q                   <= rem_c_n;
				down_q                 <= rem_c_n;
				rr_q                   <= rem_r_n;
				lane_col_q[MAX_RADIUS] <= rem_c_n;
			end
		end
		// fill lanes outward from the center, and step the row back by the radius
		if (state_q == ST_WALK) begin
			up_q   <= up_n;
			down_q <= down_n;
			for (int k = 0; k < LANES; k++) begin
				if (k > MAX_RADIUS && step_q == RW'(k - MAX_RADIUS)) begin
					lane_col_q[k] <= up_n;
				end
				if (k < MAX_RADIUS && step_q == RW'(MAX_RADIUS - k)) begin
					lane_col_q[k] <= down_n;
				end
			end
			if (step_q <= r_eff) begin
				rr_q <= rr_dec;
			end
			dr_q <= -$signed({1'b0, r_eff});
		end
		if (state_q == ST_ROWS) begin
			rr_q   <= rr_inc;
			dr_q   <= dr_q + (RW+1)'(1);
			dr2_s1 <= SQ1W'(abs_dr) * SQ1W'(abs_dr);
		end
		hits_s2 <= hits;
		if (v_s2) begin
			acc_q <= acc_q + ACCW'(pop);
		end
		if (state_q == ST_DONE && (!m_tvalid_q || m_tready)) begin
			count_q <= count_sat;
		end
	end

	// checks
	a_mem_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("grid memory read and written in the same cycle");

	a_row_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |=> v_s2)
		else $error("row read lost between memory output and count stage");

	a_result_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && (!m_tvalid_q || m_tready))
		|=> (m_tvalid && state_q == ST_IDLE))
		else $error("finished query did not present its count");

	a_no_req_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLR) |=> (state_q == ST_CLR ||
		(state_q == ST_IDLE && $past(clr_q) == AW'(MAX_SIZE - 1))))
		else $error("grid clear left before the last row");

endmodule

/* tb/torus_disc_neighbour_count_unit_test.sv */
// self-checking stream bench for the torus disc neighbour count unit
module torus_disc_neighbour_count_unit_test;
	import tdnc_pkg::*;

	localparam int HALF_PERIOD  = 5;
	localparam int RESET_CYCLES = 11;
	localparam int DRAIN_CYCLES = 200;
	localparam int HOLD_CYCLES  = 900;
	localparam int LIMIT_CYCLES = 1500000;
	localparam int BUSY_PCT     = 77;
	localparam int LIGHT_PCT    = 13;

	typedef struct {
		req_type_t          kind;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic               mark;
	} grid_req_t;

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [TDATA_IN_W-1:0]  s_tdata  = '0;   // row[8:0], col[17:9], mark[18], zero fill
	logic                   s_tuser  = 1'b0; // req_type
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [TDATA_OUT_W-1:0] m_tdata;         // count[11:0], zero fill
	logic                   psel     = 1'b0;
	logic                   penable  = 1'b0;
	logic                   pwrite   = 1'b0;
	logic [PADDR_W-1:0]     paddr    = '0;
	logic [PDATA_W-1:0]     pwdata   = '0;
	logic [PDATA_W-1:0]     prdata;
	logic                   pready;

	// model of the unit: mark grid and register copies
	bit                 mark_grid [MAX_SIZE_DEF][MAX_SIZE_DEF];
	logic [GRID_W-1:0]  cfg_grid   = GRID_RESET;
	logic [RAD_W-1:0]   cfg_radius = RADIUS_RESET;

	grid_req_t          req_backlog [$];
	logic [COUNT_W-1:0] expected_counts [$];
	grid_req_t          offered;
	logic [COUNT_W-1:0] count_want;
	int                 send_idle_pct  = 0;
	int                 recv_stall_pct = 0;
	int                 hold_off_ask   = 0;
	int                 hold_off_seen  = 0;
	int                 hold_left      = 0;
	int                 fail_cnt       = 0;
	int                 cycle_cnt      = 0;

	torus_disc_neighbour_count_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #HALF_PERIOD clk = ~clk;

	function automatic int grid_side();
		int n;
		n = int'(cfg_grid);
		if (n == 0) n = 1;
		if (n > MAX_SIZE_DEF) n = MAX_SIZE_DEF;
		return n;
	endfunction

	function automatic int torus_wrap(int v, int n);
		int m;
		m = v % n;
		if (m < 0) m += n;
		return m;
	endfunction

	// every offset inside the disc counts, even when wrapping hits the same cell twice
	function automatic logic [COUNT_W-1:0] disc_count(int r0, int c0, int n);
		int r;
		int total;
		r = int'(cfg_radius);
		if (r > MAX_RADIUS_DEF) r = MAX_RADIUS_DEF;
		total = 0;
		for (int dr = -r; dr <= r; dr++) begin
			for (int dc = -r; dc <= r; dc++) begin
				if (dr * dr + dc * dc <= r * r &&
				    mark_grid[torus_wrap(r0 + dr, n)][torus_wrap(c0 + dc, n)])
					total++;
			end
		end
		if (total > COUNT_MAX) total = COUNT_MAX;
		return COUNT_W'(total);
	endfunction

	function automatic void predict_request(grid_req_t req);
		int n;
		int r0;
		int c0;
		n  = grid_side();
		r0 = torus_wrap(int'(req.row), n);
		c0 = torus_wrap(int'(req.col), n);
		if (req.kind == REQ_WRITE)
			mark_grid[r0][c0] = req.mark;
		else
			expected_counts.push_back(disc_count(r0, c0, n));
	endfunction

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				predict_request(offered);
			if (!s_tvalid || s_tready) begin
				if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					offered = req_backlog.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= TDATA_IN_W'({offered.mark, offered.col, offered.row});
					s_tuser  <= offered.kind;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// count monitor and receiver stall
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_counts.size() == 0) begin
					$display("%0t: unexpected count, expected none actual %0d",
						$time, m_tdata[COUNT_W-1:0]);
					fail_cnt++;
				end else begin
					count_want = expected_counts.pop_front();
					if (m_tdata[COUNT_W-1:0] !== count_want) begin
						$display("%0t: count mismatch, expected %0d actual %0d",
							$time, count_want, m_tdata[COUNT_W-1:0]);
						fail_cnt++;
					end
				end
			end
			if (hold_off_ask != hold_off_seen) begin
				hold_off_seen = hold_off_ask;
				hold_left     = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= LIMIT_CYCLES) begin
			$display("torus_disc_neighbour_count_unit regression: fail");
			$finish;
		end
	end

	task automatic reg_write(logic [REG_IDX_W-1:0] idx, logic [PDATA_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(posedge clk);
		end while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == REG_GRID_SIZE)
			cfg_grid = value[GRID_W-1:0];
		else
			cfg_radius = value[RAD_W-1:0];
	endtask

	// writes give no count, so drain for a full query time after the last count
	task automatic wait_idle();
		do begin
			@(negedge clk);
		end while (req_backlog.size() != 0 || s_tvalid || expected_counts.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_phase(logic [PDATA_W-1:0] grid_val, logic [PDATA_W-1:0] rad_val,
		int send_pct, int recv_pct);
		wait_idle();
		reg_write(REG_GRID_SIZE, grid_val);
		reg_write(REG_RADIUS, rad_val);
		@(negedge clk);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	task automatic push_req(req_type_t kind, int row, int col, logic mark);
		grid_req_t req;
		req.kind = kind;
		req.row  = COORD_W'(row);
		req.col  = COORD_W'(col);
		req.mark = mark;
		req_backlog.push_back(req);
	endtask

	// coordinates mostly inside a window so marks pile up near the queries
	task automatic queue_random(int n_items, int span, int pct_query);
		grid_req_t req;
		int        base_r;
		int        base_c;
		base_r = $urandom_range(511);
		base_c = $urandom_range(511);
		if (span < 64) begin
			base_r = 0;
			base_c = 0;
		end
		for (int i = 0; i < n_items; i++) begin
			req.kind = ($urandom_range(99) < pct_query) ? REQ_QUERY : REQ_WRITE;
			req.mark = ($urandom_range(99) < 65);
			if ($urandom_range(3) == 0)
				req.row = COORD_W'($urandom_range(511));
			else
				req.row = COORD_W'((base_r + $urandom_range(span - 1)) % 512);
			if ($urandom_range(3) == 0)
				req.col = COORD_W'($urandom_range(511));
			else
				req.col = COORD_W'((base_c + $urandom_range(span - 1)) % 512);
			req_backlog.push_back(req);
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// reset values, marks across the corner of the grid
		push_req(REQ_QUERY, 0, 0, 1'b1);
		push_req(REQ_WRITE, 0, 0, 1'b1);
		push_req(REQ_WRITE, 511, 511, 1'b1);
		push_req(REQ_WRITE, 0, 5, 1'b1);
		push_req(REQ_WRITE, 5, 0, 1'b1);
		push_req(REQ_WRITE, 4, 3, 1'b1);
		push_req(REQ_WRITE, 4, 4, 1'b1);
		push_req(REQ_WRITE, 0, 506, 1'b1);
		push_req(REQ_WRITE, 507, 0, 1'b1);
		push_req(REQ_QUERY, 0, 0, 1'b0);
		push_req(REQ_QUERY, 511, 511, 1'b1);
		push_req(REQ_WRITE, 0, 0, 1'b0);
		push_req(REQ_QUERY, 0, 0, 1'b0);

		// zero size acts as one cell, full radius counts it at every offset
		set_phase(32'd0, 32'd31, 0, 0);
		push_req(REQ_QUERY, 0, 0, 1'b0);
		push_req(REQ_WRITE, 300, 400, 1'b1);
		push_req(REQ_QUERY, 511, 511, 1'b0);

		// oversized size saturates, stray upper bits dropped
		set_phase(32'hFFFF_FFFF, 32'h1234_5660, 0, 0);
		push_req(REQ_QUERY, 0, 0, 1'b0);
		push_req(REQ_QUERY, 4, 3, 1'b1);
		push_req(REQ_QUERY, 1, 1, 1'b0);

		set_phase(32'd2, 32'd1, 0, 0);
		push_req(REQ_QUERY, 0, 0, 1'b0);
		push_req(REQ_QUERY, 1, 1, 1'b1);
		push_req(REQ_WRITE, 1, 1, 1'b1);
		push_req(REQ_QUERY, 0, 1, 1'b0);

		set_phase(32'd8, 32'd3, 0, 0);
		queue_random(140, 8, 45);

		set_phase(32'd16, 32'd7, BUSY_PCT, 0);
		queue_random(140, 16, 45);

		set_phase(32'd5, 32'd31, 0, BUSY_PCT);
		queue_random(120, 5, 40);

		// full grid, long receiver hold-off so the unit backs up into its input
		set_phase(32'd512, 32'd5, LIGHT_PCT, LIGHT_PCT);
		queue_random(150, 14, 50);
		hold_off_ask++;

		set_phase(32'hABCD_0025, 32'd0, 0, BUSY_PCT);
		queue_random(130, 37, 45);

		set_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0);
		queue_random(130, 40, 45);
		hold_off_ask++;

		set_phase(32'd1, 32'd2, LIGHT_PCT, LIGHT_PCT);
		queue_random(120, 1, 45);

		wait_idle();
		if (fail_cnt == 0 && expected_counts.size() == 0) begin
			$display("torus_disc_neighbour_count_unit regression: pass");
		end else begin
			$display("torus_disc_neighbour_count_unit regression: fail");
		end
		$finish;
	end

endmodule

/* files.f */
hw/rtl/tdnc_pkg.sv
hw/rtl/torus_disc_neighbour_count_unit.sv
tb/torus_disc_neighbour_count_unit_test.sv
